// ===== hdl/crclr_pkg.sv =====
package crclr_pkg;

  localparam int unsigned LINE_MAX = 511;
  localparam int unsigned CNT_W    = $clog2(LINE_MAX + 1);
  localparam int unsigned FIELD_W  = 9;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HEX     = 2'd2;

  localparam logic [2:0] VD_PLAIN    = 3'd0;
  localparam logic [2:0] VD_VERIFIED = 3'd1;
  localparam logic [2:0] VD_NO_STAR  = 3'd2;
  localparam logic [2:0] VD_BAD_HEX  = 3'd3;
  localparam logic [2:0] VD_MISMATCH = 3'd4;

  // Result transaction, lowest field last
  typedef struct packed {
    logic [1:0]         pad;
    logic [15:0]        computed_crc;
    logic [15:0]        received_crc;
    logic [FIELD_W-1:0] payload_length;
    logic [FIELD_W-1:0] payload_start;
    logic [FIELD_W-1:0] line_length;
    logic [2:0]         verdict;
  } result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = {1'b0, 4'(c - 8'h37)};
    end
    return n;
  endfunction

  // Matched length of the prefix after byte c; 3'd4 means complete
  function automatic logic [2:0] match_step(input logic [1:0] p, input logic [7:0] c);
    logic [7:0] want;
    logic [2:0] r;
    case (p)
      2'd0:    want = CH_C;
      2'd1:    want = CH_R;
      2'd2:    want = CH_C;
      default: want = CH_COLON;
    endcase
    if (c == want) begin
      r = {1'b0, p} + 3'd1;
    end else if (p == 2'd3 && c == CH_R) begin
      r = 3'd2;
    end else if (c == CH_C) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/crc_checked_line_receiver_unit.sv =====
// A newline byte is first held in the input register; when it retires, a line that is neither
//   empty nor overflowed loads its verdict into the result register and raises m_tvalid.
// Throughput: one byte per cycle; the input register stalls only when a newline meets a
//   result that is still waiting to be taken.
// Reset (rst, synchronous, active high): empties both registers and clears all line state.
module crc_checked_line_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // verdict, line_length, payload_start, payload_length,
                                 // received_crc, computed_crc, 2 zero bits
);

  localparam int unsigned CW = crclr_pkg::CNT_W;
  localparam int unsigned FW = crclr_pkg::FIELD_W;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // per-line state
  logic [CW-1:0] line_count,      line_count_next;
  logic          overflowed,      overflowed_next;
  logic [1:0]    phase,           phase_next;
  logic [1:0]    prefix_progress, prefix_progress_next;
  logic [15:0]   crc_reg,         crc_reg_next;
  logic [15:0]   hex_value,       hex_value_next;
  logic [2:0]    hex_digits_seen, hex_digits_seen_next;
  logic          hex_invalid,     hex_invalid_next;
  logic [CW-1:0] payload_begin,   payload_begin_next;
  logic [CW-1:0] payload_count,   payload_count_next;
  logic          text_ended,      text_ended_next;

  // result register
  crclr_pkg::result_t result, result_next;
  logic               emit;
  logic               advance;
  logic [2:0]         match;
  logic [4:0]         nib;

  // A newline may only retire once the result register is free
  assign advance  = in_valid && !(in_byte == crclr_pkg::CH_LF && m_tvalid && !m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = result;

  assign match = crclr_pkg::match_step(prefix_progress, in_byte);
  assign nib   = crclr_pkg::nibble_of(in_byte);

  always_comb begin
    line_count_next      = line_count;
    overflowed_next      = overflowed;
    phase_next           = phase;
    prefix_progress_next = prefix_progress;
    crc_reg_next         = crc_reg;
    hex_value_next       = hex_value;
    hex_digits_seen_next = hex_digits_seen;
    hex_invalid_next     = hex_invalid;
    payload_begin_next   = payload_begin;
    payload_count_next   = payload_count;
    text_ended_next      = text_ended;
    emit                 = 1'b0;

    result_next                = '0;
    result_next.verdict        = crclr_pkg::VD_PLAIN;
    result_next.line_length    = FW'(line_count);
    result_next.payload_length = FW'(line_count);

    unique case (phase)
      crclr_pkg::PH_PAYLOAD: begin
        result_next.verdict        = crclr_pkg::VD_NO_STAR;
        result_next.payload_start  = FW'(payload_begin);
        result_next.payload_length = FW'(payload_count);
        result_next.computed_crc   = crc_reg;
      end
      crclr_pkg::PH_HEX: begin
        result_next.payload_start  = FW'(payload_begin);
        result_next.payload_length = FW'(payload_count);
        result_next.computed_crc   = crc_reg;
        if (hex_invalid || hex_digits_seen < 3'd4) begin
          result_next.verdict = crclr_pkg::VD_BAD_HEX;
        end else begin
          result_next.received_crc = hex_value;
          result_next.verdict      = (hex_value == crc_reg) ? crclr_pkg::VD_VERIFIED
                                                            : crclr_pkg::VD_MISMATCH;
        end
      end
      default: ;
    endcase

    if (advance && in_byte != crclr_pkg::CH_CR) begin
      if (in_byte == crclr_pkg::CH_LF ||
          (!overflowed && line_count >= CW'(crclr_pkg::LINE_MAX))) begin
        // end of line, or a byte too many: start a fresh line
        emit                 = (in_byte == crclr_pkg::CH_LF) && !overflowed && line_count != '0;
        overflowed_next      = (in_byte != crclr_pkg::CH_LF);
        line_count_next      = '0;
        phase_next           = crclr_pkg::PH_SEARCH;
        prefix_progress_next = 2'd0;
        crc_reg_next         = crclr_pkg::CRC_INIT;
        hex_value_next       = '0;
        hex_digits_seen_next = '0;
        hex_invalid_next     = 1'b0;
        payload_begin_next   = '0;
        payload_count_next   = '0;
        text_ended_next      = 1'b0;
      end else if (!overflowed) begin
        line_count_next = line_count + CW'(1);
        if (!text_ended) begin
          if (in_byte == crclr_pkg::CH_NUL) begin
            text_ended_next = 1'b1;
          end else begin
            unique case (phase)
              crclr_pkg::PH_SEARCH: begin
                if (match[2]) begin
                  phase_next           = crclr_pkg::PH_PAYLOAD;
                  prefix_progress_next = 2'd0;
                  payload_begin_next   = line_count + CW'(1);
                  payload_count_next   = '0;
                  crc_reg_next         = crclr_pkg::CRC_INIT;
                end else begin
                  prefix_progress_next = match[1:0];
                end
              end
              crclr_pkg::PH_PAYLOAD: begin
                if (in_byte == crclr_pkg::CH_STAR) begin
                  phase_next = crclr_pkg::PH_HEX;
                end else begin
                  crc_reg_next       = crclr_pkg::crc_byte(crc_reg, in_byte);
                  payload_count_next = payload_count + CW'(1);
                end
              end
              default: begin
                // hex digits; anything after the fourth is ignored
                if (hex_digits_seen < 3'd4) begin
                  if (nib[4]) begin
                    hex_invalid_next = 1'b1;
                  end else begin
                    hex_value_next = {hex_value[11:0], nib[3:0]};
                  end
                  hex_digits_seen_next = hex_digits_seen + 3'd1;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      line_count      <= '0;
      overflowed      <= 1'b0;
      phase           <= crclr_pkg::PH_SEARCH;
      prefix_progress <= 2'd0;
      crc_reg         <= crclr_pkg::CRC_INIT;
      hex_value       <= '0;
      hex_digits_seen <= '0;
      hex_invalid     <= 1'b0;
      payload_begin   <= '0;
      payload_count   <= '0;
      text_ended      <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      line_count      <= line_count_next;
      overflowed      <= overflowed_next;
      phase           <= phase_next;
      prefix_progress <= prefix_progress_next;
      crc_reg         <= crc_reg_next;
      hex_value       <= hex_value_next;
      hex_digits_seen <= hex_digits_seen_next;
      hex_invalid     <= hex_invalid_next;
      payload_begin   <= payload_begin_next;
      payload_count   <= payload_count_next;
      text_ended      <= text_ended_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (advance && emit) begin
      result <= result_next;
    end
  end

endmodule
